>>> hw/rtl/hashed_timing_wheel_unit_defines.svh
// Assertion macros shared by the timing wheel RTL.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH
`define HASHED_TIMING_WHEEL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timing wheel check failed");

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timing wheel check failed");

`endif

>>> hw/rtl/htw_pkg.sv
// Shared types and constants of the hashed timing wheel.
// No dependencies; used by htw_match and hashed_timing_wheel_unit.
package htw_pkg;

  // SLOTS must be a power of two so that the slot index is a plain mask.
  localparam int SLOTS      = 512;
  localparam int MAX_TIMERS = 64;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int DELAY_W = 20;
  localparam int ROUND_W = DELAY_W - SLOT_W;
  localparam int TID_W   = 6;
  localparam int IDX_W   = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
  localparam int ENTRY_W = SLOT_W + ROUND_W;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ARM    = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic EV_EXPIRED = 1'b0;
  localparam logic EV_REFUSED = 1'b1;

  typedef struct packed {
    logic               hit;
    logic               fire;
    logic [ROUND_W-1:0] rounds_dec;
  } match_t;

endpackage

>>> hw/rtl/htw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/htw_match.sv
// Shared compare unit: checks one timer entry against the current slot.
// Depends on htw_pkg.
module htw_match (
  input  logic [htw_pkg::SLOT_W-1:0]  current_slot,
  input  logic                        armed,
  input  logic [htw_pkg::SLOT_W-1:0]  slot,
  input  logic [htw_pkg::ROUND_W-1:0] rounds,
  output htw_pkg::match_t             result
);

  always_comb begin
    result.hit        = armed && (slot == current_slot);
    result.fire       = (rounds == '0);
    result.rounds_dec = rounds - htw_pkg::ROUND_W'(1);
  end

endmodule

>>> hw/rtl/hashed_timing_wheel_unit.sv
// Hashed timing wheel: a command sequencer over a timer entry RAM.
// Depends on htw_pkg, htw_ram, htw_match and hashed_timing_wheel_unit_defines.svh.
//
// Usage: an item (mode, timer_id, delay_ticks) is taken at a clock edge where
// start is high and busy is low. Each result (event_res, event_id, last) is
// shown for one cycle with strobe high; last marks the final result of an item.
// Arm and cancel keep busy high only in ST_EXEC after the item is taken; an arm
// result, if any, appears in the cycle after that.
// A tick keeps busy high through ST_EXEC, ST_SCAN and ST_FLUSH: the scan reads
// one timer entry per cycle from the single read port of the entry RAM and
// passes it through the shared compare unit. Expiries leave in ascending id
// order, each one held back by one found expiry so that last can be marked;
// the final one appears in the same cycle that busy falls.
// Reset clears the current slot, all armed flags and the sequencer; the entry
// RAM is not cleared, since entries that are not armed are ignored.
// The receiver cannot stall: results are not held.
`include "hashed_timing_wheel_unit_defines.svh"

module hashed_timing_wheel_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [htw_pkg::TID_W-1:0]   timer_id,
  input  logic [htw_pkg::DELAY_W-1:0] delay_ticks,
  output logic                        strobe,
  output logic                        event_res,
  output logic [htw_pkg::TID_W-1:0]   event_id,
  output logic                        last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t                        state;
  logic [1:0]                    op_mode;
  logic [htw_pkg::TID_W-1:0]     op_id;
  logic [htw_pkg::DELAY_W-1:0]   op_delay;
  logic [htw_pkg::SLOT_W-1:0]    current_slot;
  logic [htw_pkg::MAX_TIMERS-1:0] armed;
  logic [htw_pkg::CNT_W-1:0]     cnt;
  logic                          chk_valid;
  logic [htw_pkg::TID_W-1:0]     chk_id;
  logic                          pend_valid;
  logic [htw_pkg::TID_W-1:0]     pend_id;

  logic                          id_ok;
  logic [htw_pkg::IDX_W-1:0]     op_idx;
  logic [htw_pkg::IDX_W-1:0]     chk_idx;
  logic                          ram_we;
  logic [htw_pkg::IDX_W-1:0]     ram_waddr;
  logic [htw_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [htw_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [htw_pkg::SLOT_W-1:0]    arm_slot;
  logic [htw_pkg::ROUND_W-1:0]   arm_rounds;
  htw_pkg::match_t               match;

  assign busy    = (state != ST_IDLE);
  assign id_ok   = ({1'b0, op_id} < (htw_pkg::TID_W + 1)'(htw_pkg::MAX_TIMERS));
  assign op_idx  = op_id[htw_pkg::IDX_W-1:0];
  assign chk_idx = chk_id[htw_pkg::IDX_W-1:0];

  assign arm_slot   = current_slot + op_delay[htw_pkg::SLOT_W-1:0];
  assign arm_rounds = op_delay[htw_pkg::DELAY_W-1:htw_pkg::SLOT_W];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = op_idx;
    ram_wdata = {arm_slot, arm_rounds};
    if ((state == ST_EXEC) && (op_mode == htw_pkg::MODE_ARM) && id_ok &&
        !armed[op_idx] && (op_delay != '0)) begin
      ram_we = 1'b1;
    end else if ((state == ST_SCAN) && chk_valid && match.hit && !match.fire) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx;
      ram_wdata = {ram_rdata[htw_pkg::ENTRY_W-1:htw_pkg::ROUND_W], match.rounds_dec};
    end
  end

  htw_ram #(
    .WIDTH (htw_pkg::ENTRY_W),
    .DEPTH (htw_pkg::MAX_TIMERS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[htw_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  htw_match u_match (
    .current_slot (current_slot),
    .armed        (armed[chk_idx]),
    .slot         (ram_rdata[htw_pkg::ENTRY_W-1:htw_pkg::ROUND_W]),
    .rounds       (ram_rdata[htw_pkg::ROUND_W-1:0]),
    .result       (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_slot <= '0;
      armed        <= '0;
      cnt          <= '0;
      chk_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op_mode  <= mode;
            op_id    <= timer_id;
            op_delay <= delay_ticks;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          case (op_mode)
            htw_pkg::MODE_TICK: begin
              current_slot <= current_slot + htw_pkg::SLOT_W'(1);
              cnt          <= '0;
              chk_valid    <= 1'b0;
              pend_valid   <= 1'b0;
              state        <= ST_SCAN;
            end
            htw_pkg::MODE_ARM: begin
              if (id_ok) begin
                if (armed[op_idx]) begin
                  strobe    <= 1'b1;
                  event_res <= htw_pkg::EV_REFUSED;
                  event_id  <= op_id;
                  last      <= 1'b1;
                end else if (op_delay == '0) begin
                  strobe    <= 1'b1;
                  event_res <= htw_pkg::EV_EXPIRED;
                  event_id  <= op_id;
                  last      <= 1'b1;
                end else begin
                  armed[op_idx] <= 1'b1;
                end
              end
            end
            htw_pkg::MODE_CANCEL: begin
              if (id_ok) begin
                armed[op_idx] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          if (chk_valid && match.hit && match.fire) begin
            armed[chk_idx] <= 1'b0;
            if (pend_valid) begin
              strobe    <= 1'b1;
              event_res <= htw_pkg::EV_EXPIRED;
              event_id  <= pend_id;
              last      <= 1'b0;
            end
            pend_id    <= chk_id;
            pend_valid <= 1'b1;
          end
          if (cnt == htw_pkg::CNT_W'(htw_pkg::MAX_TIMERS)) begin
            chk_valid <= 1'b0;
            state     <= ST_FLUSH;
          end else begin
            chk_valid <= 1'b1;
            chk_id    <= htw_pkg::TID_W'(cnt);
            cnt       <= cnt + htw_pkg::CNT_W'(1);
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            strobe    <= 1'b1;
            event_res <= htw_pkg::EV_EXPIRED;
            event_id  <= pend_id;
            last      <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `HTW_ASSERT_NEXT(a_last_ends_burst, strobe && last, !strobe)
  `HTW_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `HTW_ASSERT_IMPL(a_write_in_work, ram_we, (state == ST_EXEC) || (state == ST_SCAN))
  `HTW_ASSERT_IMPL(a_scan_bound, state == ST_SCAN, cnt <= htw_pkg::CNT_W'(htw_pkg::MAX_TIMERS))

endmodule
